// ===== design/mbnc_pkg.sv =====
// Shared types and constants for the markup block node counter.
package mbnc_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned COUNT_W = 32;

  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
  localparam logic [7:0] CH_LBRACE     = 8'h7B;
  localparam logic [7:0] CH_RBRACE     = 8'h7D;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_COLON      = 8'h3A;
  localparam logic [7:0] CH_EQUALS     = 8'h3D;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_SEMICOLON  = 8'h3B;
  localparam logic [7:0] CH_LOWER_A    = 8'h61;
  localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
  localparam logic [7:0] CH_UPPER_A    = 8'h41;
  localparam logic [7:0] CH_UPPER_Z    = 8'h5A;

  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_SLASH,
    CLS_QUOTE,
    CLS_BACKSLASH,
    CLS_IDENT,
    CLS_LBRACE,
    CLS_SEPARATOR,
    CLS_NEWLINE
  } char_class_e;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_STRING,
    MODE_COMMENT
  } scan_mode_e;

  typedef struct packed {
    char_class_e cls;
    logic        is_last;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== design/markup_block_node_counter.sv =====
// Top level of the markup block node counter.
// A byte request accepted into the queue is scanned when the back end pops it; the
// result of a last byte is registered when that byte is scanned.
// Throughput: one byte per cycle while the result is not stalled, set by the one-entry-per-cycle back end scan.
// The queue between front and back ends holds QueueDepth classified bytes.
// Reset is asynchronous and active low; it empties the queue and clears the scan state.
module markup_block_node_counter
  import mbnc_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         char_code_i,
  input  logic               is_last_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [COUNT_W-1:0] node_count_o
);

  queue_status_t q_status;
  entry_t        push_entry;
  entry_t        head_entry;
  logic          push;
  logic          pop;

  mbnc_front u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_code_i    (char_code_i),
    .is_last_i      (is_last_i),
    .queue_status_i (q_status),
    .push_o         (push),
    .entry_o        (push_entry)
  );

  mbnc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .entry_o  (head_entry),
    .status_o (q_status)
  );

  mbnc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .entry_i      (head_entry),
    .avail_i      (!q_status.empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .node_count_o (node_count_o)
  );

  // The queue is never reported full and empty at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_status.full && q_status.empty))
    else $error("queue status is both full and empty");

  // The back end never takes a byte while its result register is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !pop)
    else $error("byte taken while result is stalled");

  // Bytes are only taken from a non-empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");

  // A push into a full queue cannot happen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_status.full)
    else $error("push into full queue");

endmodule

// ===== design/mbnc_front.sv =====
// Front end: takes byte requests and classifies each byte for the back end.
module mbnc_front
  import mbnc_pkg::*;
(
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    char_code_i,
  input  logic          is_last_i,
  input  queue_status_t queue_status_i,
  output logic          push_o,
  output entry_t        entry_o
);

  char_class_e cls;

  always_comb begin
    if (char_code_i == CH_SLASH) begin
      cls = CLS_SLASH;
    end else if (char_code_i == CH_QUOTE) begin
      cls = CLS_QUOTE;
    end else if (char_code_i == CH_BACKSLASH) begin
      cls = CLS_BACKSLASH;
    end else if (char_code_i inside {[CH_LOWER_A:CH_LOWER_Z], [CH_UPPER_A:CH_UPPER_Z],
                                     CH_UNDERSCORE}) begin
      cls = CLS_IDENT;
    end else if (char_code_i == CH_LBRACE) begin
      cls = CLS_LBRACE;
    end else if (char_code_i inside {CH_COLON, CH_EQUALS, CH_RBRACE, CH_LPAREN,
                                     CH_RPAREN, CH_SEMICOLON}) begin
      cls = CLS_SEPARATOR;
    end else if (char_code_i == CH_NEWLINE) begin
      cls = CLS_NEWLINE;
    end else begin
      cls = CLS_OTHER;
    end
  end

  assign in_stall_o      = queue_status_i.full;
  assign push_o          = in_valid_i && !queue_status_i.full;
  assign entry_o.cls     = cls;
  assign entry_o.is_last = is_last_i;

endmodule

// ===== design/mbnc_queue.sv =====
// Short register queue of classified bytes between the front and back ends.
module mbnc_queue
  import mbnc_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  entry_t        entry_i,
  input  logic          pop_i,
  output entry_t        entry_o,
  output queue_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            entries_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign status_o.full  = (cnt_q == CntW'(Depth));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign entry_o        = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== design/mbnc_back.sv =====
// Back end: scan state machine, node counting and the registered result.
module mbnc_back
  import mbnc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  entry_t             entry_i,
  input  logic               avail_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [COUNT_W-1:0] node_count_o
);

  scan_mode_e         mode_q, mode_d;
  logic               esc_q, esc_d;
  logic               saw_q, saw_d;
  logic               slash_q, slash_d;
  logic [COUNT_W-1:0] total_q, total_d;
  logic               out_valid_q, out_valid_d;
  logic [COUNT_W-1:0] out_data_q, out_data_d;
  logic               emit;

  assign pop_o        = avail_i && !(out_valid_q && out_stall_i);
  assign out_valid_o  = out_valid_q;
  assign node_count_o = out_data_q;

  always_comb begin
    mode_d      = mode_q;
    esc_d       = esc_q;
    saw_d       = saw_q;
    slash_d     = slash_q;
    total_d     = total_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && out_stall_i;
    emit        = 1'b0;
    if (pop_o) begin
      case (mode_q)
        MODE_COMMENT: begin
          if (entry_i.cls == CLS_NEWLINE) begin
            mode_d = MODE_NORMAL;
          end
        end
        MODE_STRING: begin
          if (!esc_q && entry_i.cls == CLS_QUOTE) begin
            mode_d = MODE_NORMAL;
          end else begin
            esc_d = (entry_i.cls == CLS_BACKSLASH) && !esc_q;
          end
        end
        default: begin
          if (slash_q && entry_i.cls == CLS_SLASH) begin
            slash_d = 1'b0;
            mode_d  = MODE_COMMENT;
          end else begin
            slash_d = 1'b0;
            case (entry_i.cls)
              CLS_SLASH: begin
                slash_d = 1'b1;
              end
              CLS_QUOTE: begin
                mode_d = MODE_STRING;
                esc_d  = 1'b0;
              end
              CLS_IDENT: begin
                saw_d = 1'b1;
              end
              CLS_LBRACE: begin
                if (saw_q && total_q != '1) begin
                  total_d = total_q + COUNT_W'(1);
                end
                saw_d = 1'b0;
              end
              CLS_SEPARATOR: begin
                saw_d = 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
      endcase
      emit = entry_i.is_last;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      out_data_d  = total_d;
      mode_d      = MODE_NORMAL;
      esc_d       = 1'b0;
      saw_d       = 1'b0;
      slash_d     = 1'b0;
      total_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_NORMAL;
      esc_q       <= 1'b0;
      saw_q       <= 1'b0;
      slash_q     <= 1'b0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      esc_q       <= esc_d;
      saw_q       <= saw_d;
      slash_q     <= slash_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

endmodule
